/* hdl/vdi_pkg.sv */
// Shared types, constants and helper function of the vertex dedup indexer.
// Used by vdi_match, vdi_accum and the top level; depends on nothing else.
package vdi_pkg;

  localparam int MAX_VERTICES = 4096;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int COMP_W       = 16;
  localparam int SUM_W        = 20;
  localparam int TOL_W        = 16;
  localparam int KEY_COMPS    = 8;
  localparam int KEY_W        = KEY_COMPS * COMP_W;
  localparam int ACC_COMPS    = 6;
  localparam int DELTA_W      = ACC_COMPS * COMP_W;
  localparam int SUMS_W       = ACC_COMPS * SUM_W;
  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(41);

  typedef struct packed {
    logic        mode;
    logic [11:0] read_index;
    logic [47:0] position_in;
    logic [47:0] normal_in;
    logic [31:0] uv_in;
    logic [47:0] tangent_in;
    logic [47:0] bitangent_in;
  } vdi_in_t;

  typedef struct packed {
    logic [11:0] vertex_index;
    logic        is_new;
    logic        table_full;
    logic [59:0] tangent_sum;
    logic [59:0] bitangent_sum;
  } vdi_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HIT_RD,
    ST_HIT_UPD,
    ST_MISS,
    ST_RD_RD,
    ST_RD_OUT,
    ST_FINISH
  } vdi_state_t;

  localparam logic MODE_SUBMIT = 1'b0;
  localparam logic MODE_READ   = 1'b1;

  // Adds one signed component into a signed sum and clamps to the sum range.
  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0]  s,
                                               input logic [COMP_W-1:0] c);
    logic [SUM_W:0] t;
    t = {s[SUM_W-1], s} + {{(SUM_W + 1 - COMP_W){c[COMP_W-1]}}, c};
    if (t[SUM_W] != t[SUM_W-1]) begin
      sat_add = t[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sat_add = t[SUM_W-1:0];
    end
  endfunction

endpackage

/* hdl/vdi_ram.sv */
// Generic single write port, single read port RAM with a registered read.
// Stand-alone; used for the key store and the sum store.
module vdi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* hdl/vdi_match.sv */
// Tolerance compare unit: checks all eight key components of one stored entry.
// Depends on vdi_pkg.
module vdi_match
  import vdi_pkg::*;
(
  input  logic [KEY_W-1:0] key_a,
  input  logic [KEY_W-1:0] key_b,
  input  logic [TOL_W-1:0] tol,
  output logic             hit
);

  always_comb begin
    logic [COMP_W:0] d;
    logic [COMP_W:0] mag;
    hit = 1'b1;
    for (int k = 0; k < KEY_COMPS; k++) begin
      d = {key_a[k*COMP_W + COMP_W-1], key_a[k*COMP_W +: COMP_W]}
        - {key_b[k*COMP_W + COMP_W-1], key_b[k*COMP_W +: COMP_W]};
      mag = d[COMP_W] ? (~d + 1'b1) : d;
      if (mag >= {1'b0, tol}) begin
        hit = 1'b0;
      end
    end
  end

endmodule

/* hdl/vdi_accum.sv */
// Saturating accumulate unit for the six tangent and bitangent components.
// Depends on vdi_pkg.
module vdi_accum
  import vdi_pkg::*;
(
  input  logic [SUMS_W-1:0]  sums_in,
  input  logic [DELTA_W-1:0] delta,
  output logic [SUMS_W-1:0]  sums_out
);

  always_comb begin
    for (int k = 0; k < ACC_COMPS; k++) begin
      sums_out[k*SUM_W +: SUM_W] = sat_add(sums_in[k*SUM_W +: SUM_W],
                                           delta[k*COMP_W +: COMP_W]);
    end
  end

endmodule

/* hdl/vertex_dedup_indexer_top.sv */
// Top level of the vertex dedup indexer: sequencer, key and sum stores.
// Depends on vdi_pkg, vdi_ram, vdi_match and vdi_accum.
//
// Usage: one input transfer carries a whole vertex (mode 0) or a read request
// (mode 1). The block takes a transfer only when it is idle; in_stall is high
// for the whole time an item is being worked on. Results leave through an
// output register, one transfer per input item, and the next input item is
// accepted while that result still waits for the receiver.
// A vertex submission scans the stored entries in insertion order, one entry
// per cycle through the shared compare unit, fed by the registered read port
// of the key store. A hit stops the scan at the first match; a miss scans
// every stored entry. The scan length is what sets throughput. Reset (rst,
// synchronous) empties the table by clearing the entry count and restores
// the match tolerance to 41; store contents are not cleared, since entries
// beyond the count are never looked at. When the receiver stalls, the
// finished result stays in the output register and a following item waits in
// its final state until the register frees up. The user must write the
// tolerance register (cfg_wr_en, cfg_wr_data) only while the block is idle;
// the block itself does not enforce this.
module vertex_dedup_indexer_top
  import vdi_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [TOL_W-1:0] cfg_wr_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  vdi_in_t          in_item,
  output logic             out_valid,
  input  logic             out_stall,
  output vdi_out_t         out_item
);

  vdi_state_t state, state_next;
  vdi_in_t    item;
  logic [TOL_W-1:0] tol;
  logic [CNT_W-1:0] entry_count, entry_count_next;
  logic [CNT_W-1:0] scan_addr, scan_addr_next;
  logic             cmp_valid, cmp_valid_next;
  logic [IDX_W-1:0] cmp_idx, cmp_idx_next;
  vdi_out_t         res, res_next;
  logic             out_valid_next;
  vdi_out_t         out_item_next;

  logic [KEY_W-1:0]  item_key;
  logic [KEY_W-1:0]  key_rdata;
  logic              key_we;
  logic [SUMS_W-1:0] sum_rdata;
  logic [SUMS_W-1:0] sum_wdata;
  logic              sum_we;
  logic [IDX_W-1:0]  sum_waddr;
  logic [IDX_W-1:0]  sum_raddr;
  logic [SUMS_W-1:0] acc_in;
  logic [SUMS_W-1:0] acc_out;
  logic              hit;

  assign item_key = {item.uv_in, item.normal_in, item.position_in};
  assign in_stall = (state != ST_IDLE);

  vdi_ram #(.WIDTH(KEY_W), .DEPTH(MAX_VERTICES)) u_key_ram (
    .clk     (clk),
    .wr_en   (key_we),
    .wr_addr (entry_count[IDX_W-1:0]),
    .wr_data (item_key),
    .rd_addr (scan_addr[IDX_W-1:0]),
    .rd_data (key_rdata)
  );

  vdi_ram #(.WIDTH(SUMS_W), .DEPTH(MAX_VERTICES)) u_sum_ram (
    .clk     (clk),
    .wr_en   (sum_we),
    .wr_addr (sum_waddr),
    .wr_data (sum_wdata),
    .rd_addr (sum_raddr),
    .rd_data (sum_rdata)
  );

  vdi_match u_match (
    .key_a (item_key),
    .key_b (key_rdata),
    .tol   (tol),
    .hit   (hit)
  );

  // The accumulate unit serves both the hit update and the fresh append,
  // where it starts from an all-zero sum.
  assign acc_in = (state == ST_HIT_UPD) ? sum_rdata : '0;

  vdi_accum u_accum (
    .sums_in  (acc_in),
    .delta    ({item.bitangent_in, item.tangent_in}),
    .sums_out (acc_out)
  );

  assign sum_wdata = acc_out;
  assign sum_raddr = (state == ST_HIT_RD) ? cmp_idx : item.read_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      tol         <= TOL_RESET;
      entry_count <= '0;
      cmp_valid   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      entry_count <= entry_count_next;
      cmp_valid   <= cmp_valid_next;
      out_valid   <= out_valid_next;
      if (cfg_wr_en) begin
        tol <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      item <= in_item;
    end
    scan_addr <= scan_addr_next;
    cmp_idx   <= cmp_idx_next;
    res       <= res_next;
    out_item  <= out_item_next;
  end

  always_comb begin
    state_next       = state;
    entry_count_next = entry_count;
    scan_addr_next   = scan_addr;
    cmp_valid_next   = cmp_valid;
    cmp_idx_next     = cmp_idx;
    res_next         = res;
    out_valid_next   = out_valid;
    out_item_next    = out_item;
    key_we           = 1'b0;
    sum_we           = 1'b0;
    sum_waddr        = cmp_idx;

    // The receiver takes the waiting result.
    if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end

    case (state)
      ST_IDLE: begin
        scan_addr_next = '0;
        cmp_valid_next = 1'b0;
        if (in_valid) begin
          state_next = (in_item.mode == MODE_READ) ? ST_RD_RD : ST_SCAN;
        end
      end
      ST_SCAN: begin
        // The compare of the entry read last cycle takes priority; the
        // first hit in insertion order stops the scan.
        if (cmp_valid && hit) begin
          cmp_valid_next = 1'b0;
          state_next     = ST_HIT_RD;
        end else if (scan_addr < entry_count) begin
          cmp_valid_next = 1'b1;
          cmp_idx_next   = scan_addr[IDX_W-1:0];
          scan_addr_next = scan_addr + 1'b1;
        end else begin
          cmp_valid_next = 1'b0;
          if (!cmp_valid) begin
            state_next = ST_MISS;
          end
        end
      end
      ST_HIT_RD: begin
        state_next = ST_HIT_UPD;
      end
      ST_HIT_UPD: begin
        sum_we                 = 1'b1;
        sum_waddr              = cmp_idx;
        res_next.vertex_index  = cmp_idx;
        res_next.is_new        = 1'b0;
        res_next.table_full    = 1'b0;
        res_next.tangent_sum   = acc_out[SUMS_W/2-1:0];
        res_next.bitangent_sum = acc_out[SUMS_W-1:SUMS_W/2];
        state_next             = ST_FINISH;
      end
      ST_MISS: begin
        if (entry_count >= CNT_W'(MAX_VERTICES)) begin
          res_next.vertex_index  = '0;
          res_next.is_new        = 1'b0;
          res_next.table_full    = 1'b1;
          res_next.tangent_sum   = '0;
          res_next.bitangent_sum = '0;
        end else begin
          key_we                 = 1'b1;
          sum_we                 = 1'b1;
          sum_waddr              = entry_count[IDX_W-1:0];
          entry_count_next       = entry_count + 1'b1;
          res_next.vertex_index  = entry_count[IDX_W-1:0];
          res_next.is_new        = 1'b1;
          res_next.table_full    = 1'b0;
          res_next.tangent_sum   = acc_out[SUMS_W/2-1:0];
          res_next.bitangent_sum = acc_out[SUMS_W-1:SUMS_W/2];
        end
        state_next = ST_FINISH;
      end
      ST_RD_RD: begin
        state_next = ST_RD_OUT;
      end
      ST_RD_OUT: begin
        res_next.vertex_index = item.read_index;
        res_next.is_new       = 1'b0;
        res_next.table_full   = 1'b0;
        if ({1'b0, item.read_index} < entry_count) begin
          res_next.tangent_sum   = sum_rdata[SUMS_W/2-1:0];
          res_next.bitangent_sum = sum_rdata[SUMS_W-1:SUMS_W/2];
        end else begin
          res_next.tangent_sum   = '0;
          res_next.bitangent_sum = '0;
        end
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        // Hand the result over once the output register is free.
        if (!out_valid || !out_stall) begin
          out_valid_next = 1'b1;
          out_item_next  = res;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
